// ===== rtl/stbs_pkg.sv =====
// Shared constants, codes and handshake types for the sorted key table.
package stbs_pkg;

    localparam int KEY_W           = 34;
    localparam int INDEX_W         = 10;
    localparam int STATUS_W        = 2;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int S_TDATA_W       = 40;
    localparam int M_TDATA_W       = 16;
    localparam int M_PAD_W         = M_TDATA_W - INDEX_W - STATUS_W;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
    } search_req_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [INDEX_W-1:0] index;
    } search_rsp_t;

endpackage

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted key table: append and binary search over a RAM, one transaction at a time.
// Insert: result goes via T_HOLD to the output register (may stall); input ready again with it.
// Find: each probe takes S_PROBE then S_CMP; a hit ends in S_CMP, a miss in a final S_PROBE;
//   at most clog2(DEPTH)+1 probes, one RAM read and one key compare each.
// The output register holds a result while the next input transaction is taken.
// Reset (aresetn low, synchronous) empties the table; the key RAM is not cleared.
module sorted_table_binary_search import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [33:0] key, [39:34] zero
    input  logic                 s_axis_tuser,   // [0] kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // [1:0] status, [11:2] match_index, [15:12] zero
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        T_IDLE,
        T_SEARCH,
        T_HOLD
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    status_t                  res_status_reg;
    logic [INDEX_W-1:0]       res_index_reg;
    logic                     m_valid_reg;
    status_t                  m_status_reg;
    logic [INDEX_W-1:0]       m_index_reg;

    logic                     s_accept;
    logic                     in_kind;
    logic [KEY_W-1:0]         in_key;
    logic                     full;
    logic                     wr_en;
    logic                     out_free;
    logic [CNT_W+INDEX_W-1:0] count_wide;
    logic [KEY_W-1:0]         rd_data;
    logic [IDX_W-1:0]         rd_addr;
    search_req_t              req;
    search_rsp_t              rsp;

    assign s_axis_tready = (state_reg == T_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_kind       = s_axis_tuser;
    assign in_key        = s_axis_tdata[KEY_W-1:0];
    assign full          = (count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_en         = s_accept && (in_kind == KIND_INSERT) && !full;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign count_wide    = {{INDEX_W{1'b0}}, count_reg};

    assign req.start = s_accept && (in_kind == KIND_FIND);
    assign req.key   = in_key;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_index_reg, m_status_reg};

    stbs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (in_key),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stbs_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (req),
        .entry_count (count_reg),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .rsp         (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready && (state_reg != T_HOLD)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE: begin
                    if (s_accept) begin
                        if (in_kind == KIND_FIND) begin
                            state_reg <= T_SEARCH;
                        end else if (full) begin
                            res_status_reg <= ST_FULL;
                            res_index_reg  <= '0;
                            state_reg      <= T_HOLD;
                        end else begin
                            res_status_reg <= ST_INSERTED;
                            res_index_reg  <= count_wide[INDEX_W-1:0];
                            count_reg      <= count_reg + CNT_W'(1);
                            state_reg      <= T_HOLD;
                        end
                    end
                end
                T_SEARCH: begin
                    if (rsp.done) begin
                        res_status_reg <= rsp.hit ? ST_FOUND : ST_MISSING;
                        res_index_reg  <= rsp.index;
                        state_reg      <= T_HOLD;
                    end
                end
                T_HOLD: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_index_reg  <= res_index_reg;
                        state_reg    <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_done_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> state_reg == T_SEARCH)
        else $error("search result outside a find");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not advance entry count");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("input taken while a transaction is in progress");

endmodule

// ===== rtl/stbs_ram.sv =====
// Generic single-port-write, registered-read RAM.
module stbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/stbs_search.sv =====
// Binary search sequencer: one table read and one key compare per probe.
module stbs_search import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  search_req_t                        req,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]   entry_count,
    output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
    input  logic [KEY_W-1:0]                   rd_data,
    output search_rsp_t                        rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         lo_reg;
    logic [CNT_W-1:0]         end_reg;
    logic [CNT_W-1:0]         mid_reg;
    logic [KEY_W-1:0]         key_reg;
    search_rsp_t              rsp_reg;

    logic                     live;
    logic [CNT_W-1:0]         span;
    logic [CNT_W-1:0]         mid;
    logic [CNT_W+INDEX_W-1:0] mid_wide;

    assign live     = lo_reg < end_reg;
    assign span     = end_reg - lo_reg - CNT_W'(1);
    assign mid      = lo_reg + (span >> 1);
    assign rd_addr  = mid[IDX_W-1:0];
    assign mid_wide = {{INDEX_W{1'b0}}, mid_reg};
    assign rsp      = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rsp_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    rsp_reg.done <= 1'b0;
                    if (req.start) begin
                        key_reg   <= req.key;
                        lo_reg    <= '0;
                        end_reg   <= entry_count;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (live) begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end else begin
                        rsp_reg.done  <= 1'b1;
                        rsp_reg.hit   <= 1'b0;
                        rsp_reg.index <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_CMP: begin
                    if (rd_data == key_reg) begin
                        rsp_reg.done  <= 1'b1;
                        rsp_reg.hit   <= 1'b1;
                        rsp_reg.index <= mid_wide[INDEX_W-1:0];
                        state_reg     <= S_IDLE;
                    end else if (rd_data < key_reg) begin
                        lo_reg    <= mid_reg + CNT_W'(1);
                        state_reg <= S_PROBE;
                    end else begin
                        end_reg   <= mid_reg;
                        state_reg <= S_PROBE;
                    end
                end
                default: begin
                    rsp_reg.done <= 1'b0;
                    state_reg    <= S_IDLE;
                end
            endcase
        end
    end

endmodule
